FILE: sv/cpw_pkg.sv
`default_nettype none

package cpw_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 16;
    localparam int SPAN_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int APB_DATA   = 32;
    localparam int APB_ADDR   = 4;

    localparam logic [1:0] FUNC_MOVE = 2'd0;
    localparam logic [1:0] FUNC_DRAW = 2'd1;
    localparam logic [1:0] FUNC_STEP = 2'd2;

    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    localparam logic signed [COORD_BITS-1:0] WIN_MIN_RST = '1;
    localparam logic signed [COORD_BITS-1:0] WIN_MAX_RST = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [COLOR_BITS-1:0]        color;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0]        pixel_color;
        logic                         visible;
        logic                         last;
    } t_out_pixel;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_min;
        logic signed [COORD_BITS-1:0] x_max;
        logic signed [COORD_BITS-1:0] y_min;
        logic signed [COORD_BITS-1:0] y_max;
    } t_window;

endpackage

`default_nettype wire

FILE: sv/cpw_cfg_regs.sv
`default_nettype none

module cpw_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cpw_pkg::APB_ADDR-1:0]  paddr,
    input  wire logic [cpw_pkg::APB_DATA-1:0]  pwdata,
    output logic      [cpw_pkg::APB_DATA-1:0]  prdata,
    output logic                               pready,
    output cpw_pkg::t_window                   o_window
);

    cpw_pkg::t_window r_win;
    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [cpw_pkg::COORD_BITS-1:0] rd_val;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.x_min <= cpw_pkg::WIN_MIN_RST;
            r_win.x_max <= cpw_pkg::WIN_MAX_RST;
            r_win.y_min <= cpw_pkg::WIN_MIN_RST;
            r_win.y_max <= cpw_pkg::WIN_MAX_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cpw_pkg::REG_X_MIN: r_win.x_min <= pwdata[cpw_pkg::COORD_BITS-1:0];
                cpw_pkg::REG_X_MAX: r_win.x_max <= pwdata[cpw_pkg::COORD_BITS-1:0];
                cpw_pkg::REG_Y_MIN: r_win.y_min <= pwdata[cpw_pkg::COORD_BITS-1:0];
                cpw_pkg::REG_Y_MAX: r_win.y_max <= pwdata[cpw_pkg::COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cpw_pkg::REG_X_MIN: rd_val = r_win.x_min;
            cpw_pkg::REG_X_MAX: rd_val = r_win.x_max;
            cpw_pkg::REG_Y_MIN: rd_val = r_win.y_min;
            cpw_pkg::REG_Y_MAX: rd_val = r_win.y_max;
            default:            rd_val = '0;
        endcase
    end

    assign prdata   = {{(cpw_pkg::APB_DATA-cpw_pkg::COORD_BITS){1'b0}}, rd_val};
    assign o_window = r_win;

endmodule

`default_nettype wire

FILE: sv/cpw_walker.sv
`default_nettype none

module cpw_walker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire cpw_pkg::t_in_item   i_item,
    input  wire cpw_pkg::t_window    i_window,
    output logic                     o_res_vld,
    output cpw_pkg::t_out_pixel      o_res
);

    localparam int CB = cpw_pkg::COORD_BITS;
    localparam int SB = cpw_pkg::SPAN_BITS;
    localparam int EB = cpw_pkg::ERR_BITS;

    logic signed [CB-1:0] r_pen_x, r_pen_y, n_pen_x, n_pen_y;
    logic signed [CB-1:0] r_walk_x, r_walk_y, n_walk_x, n_walk_y;
    logic signed [CB-1:0] r_end_x, r_end_y, n_end_x, n_end_y;
    logic signed [EB-1:0] r_err, n_err;
    logic [SB-1:0]        r_span_x, r_span_y, n_span_x, n_span_y;
    logic                 r_dir_x_neg, r_dir_y_neg, n_dir_x_neg, n_dir_y_neg;
    logic                 r_active, n_active;
    logic [cpw_pkg::COLOR_BITS-1:0] r_color, n_color;

    logic signed [SB-1:0] dx, dy;
    logic signed [EB:0]   e2, neg_sy, sx_ext, err_acc;
    logic                 fin, vis;

    always_comb begin
        n_pen_x     = r_pen_x;
        n_pen_y     = r_pen_y;
        n_walk_x    = r_walk_x;
        n_walk_y    = r_walk_y;
        n_end_x     = r_end_x;
        n_end_y     = r_end_y;
        n_err       = r_err;
        n_span_x    = r_span_x;
        n_span_y    = r_span_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_active    = r_active;
        n_color     = r_color;
        o_res_vld   = 1'b0;

        dx      = {r_pen_x[CB-1], r_pen_x} - {i_item.point_x[CB-1], i_item.point_x};
        dy      = {r_pen_y[CB-1], r_pen_y} - {i_item.point_y[CB-1], i_item.point_y};
        e2      = {r_err, 1'b0};
        neg_sy  = -$signed({2'b00, r_span_y});
        sx_ext  = $signed({2'b00, r_span_x});
        err_acc = {r_err[EB-1], r_err};

        case (i_item.func)
            cpw_pkg::FUNC_MOVE: begin
                n_pen_x = i_item.point_x;
                n_pen_y = i_item.point_y;
            end
            cpw_pkg::FUNC_DRAW: begin
                n_walk_x    = i_item.point_x;
                n_walk_y    = i_item.point_y;
                n_end_x     = r_pen_x;
                n_end_y     = r_pen_y;
                n_span_x    = dx[SB-1] ? SB'(-dx) : SB'(dx);
                n_span_y    = dy[SB-1] ? SB'(-dy) : SB'(dy);
                n_dir_x_neg = !(i_item.point_x < r_pen_x);
                n_dir_y_neg = !(i_item.point_y < r_pen_y);
                n_err       = $signed({1'b0, n_span_x}) - $signed({1'b0, n_span_y});
                n_color     = i_item.color;
                n_active    = 1'b1;
                n_pen_x     = i_item.point_x;
                n_pen_y     = i_item.point_y;
                o_res_vld   = 1'b1;
            end
            cpw_pkg::FUNC_STEP: begin
                if (r_active) begin
                    if (e2 > neg_sy) begin
                        err_acc  = err_acc + neg_sy;
                        n_walk_x = r_dir_x_neg ? r_walk_x - CB'(1) : r_walk_x + CB'(1);
                    end
                    if (e2 < sx_ext) begin
                        err_acc  = err_acc + sx_ext;
                        n_walk_y = r_dir_y_neg ? r_walk_y - CB'(1) : r_walk_y + CB'(1);
                    end
                    n_err     = err_acc[EB-1:0];
                    o_res_vld = 1'b1;
                end
            end
            default: ;
        endcase

        fin = (n_walk_x == n_end_x) && (n_walk_y == n_end_y);
        vis = (n_walk_x > i_window.x_min) && (n_walk_x < i_window.x_max) &&
              (n_walk_y > i_window.y_min) && (n_walk_y < i_window.y_max);
        if (o_res_vld && fin) begin
            n_active = 1'b0;
        end

        o_res.pixel_x     = n_walk_x;
        o_res.pixel_y     = n_walk_y;
        o_res.pixel_color = n_color;
        o_res.visible     = vis;
        o_res.last        = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_walk_x    <= '0;
            r_walk_y    <= '0;
            r_end_x     <= '0;
            r_end_y     <= '0;
            r_err       <= '0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_active    <= 1'b0;
            r_color     <= '0;
        end else if (i_adv) begin
            r_pen_x     <= n_pen_x;
            r_pen_y     <= n_pen_y;
            r_walk_x    <= n_walk_x;
            r_walk_y    <= n_walk_y;
            r_end_x     <= n_end_x;
            r_end_y     <= n_end_y;
            r_err       <= n_err;
            r_span_x    <= n_span_x;
            r_span_y    <= n_span_y;
            r_dir_x_neg <= n_dir_x_neg;
            r_dir_y_neg <= n_dir_y_neg;
            r_active    <= n_active;
            r_color     <= n_color;
        end
    end

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res_vld && o_res.last) |=> !r_active)
        else $error("line still active after last pixel");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.func == cpw_pkg::FUNC_STEP && !r_active) |-> !o_res_vld)
        else $error("pixel emitted with no active line");

    a_draw_starts_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.func == cpw_pkg::FUNC_DRAW && !o_res.last) |=> r_active)
        else $error("draw did not start a line");

    a_move_keeps_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.func == cpw_pkg::FUNC_MOVE) |=> $stable(r_walk_x) && $stable(r_active))
        else $error("move disturbed the active line");

endmodule

`default_nettype wire

FILE: sv/clipped_line_pixel_walker.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_item   (cpw_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall  o_out_pixel (cpw_pkg::t_out_pixel)
// cfg       input      APB psel/penable/pwrite    paddr, pwdata, prdata
//
// Every transaction passes the input register, and each pixel the result
// register; one transaction per cycle sustained while the output is not stalled.
// The Bresenham update is a single add-compare pass between those registers.
// Reset (synchronous, active low) clears the pen and the line state and restores
// the default window.
// A stalled result holds the result register; the input register still takes
// one more transaction if it is empty, after which o_in_stall rises.

module clipped_line_pixel_walker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire cpw_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output cpw_pkg::t_out_pixel                o_out_pixel,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cpw_pkg::APB_ADDR-1:0]  paddr,
    input  wire logic [cpw_pkg::APB_DATA-1:0]  pwdata,
    output logic      [cpw_pkg::APB_DATA-1:0]  prdata,
    output logic                               pready
);

    logic                r_in_vld;
    cpw_pkg::t_in_item   r_in_item;
    logic                r_out_vld;
    cpw_pkg::t_out_pixel r_out_pixel;

    cpw_pkg::t_window     window;
    cpw_pkg::t_out_pixel  res;
    logic                 res_vld;
    logic                 out_free;
    logic                 adv;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    cpw_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (window)
    );

    cpw_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_item    (r_in_item),
        .i_window  (window),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_vld) begin
            r_out_pixel <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_pixel = r_out_pixel;

endmodule

`default_nettype wire

FILE: tb/sv/clipped_line_pixel_walker_test.sv
`timescale 1ns / 1ps

module clipped_line_pixel_walker_test;

    typedef logic signed [cpw_pkg::COORD_BITS-1:0] t_coord;

    typedef enum int {
        RX_NONE,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } t_rx_mode;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam t_coord COORD_LO = {1'b1, {(cpw_pkg::COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_HI = {1'b0, {(cpw_pkg::COORD_BITS-1){1'b1}}};
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT = 2000;

    class t_line_tracker;
        t_coord x_min, x_max, y_min, y_max;
        t_coord pen_x, pen_y, walk_x, walk_y, end_x, end_y;
        logic signed [cpw_pkg::ERR_BITS-1:0] err;
        logic [cpw_pkg::SPAN_BITS-1:0] span_x, span_y;
        logic dir_x_neg, dir_y_neg, line_active;
        logic [cpw_pkg::COLOR_BITS-1:0] line_color;
        cpw_pkg::t_out_pixel pending_pixels[$];
        int errors;

        function new();
            x_min = cpw_pkg::WIN_MIN_RST;
            x_max = cpw_pkg::WIN_MAX_RST;
            y_min = cpw_pkg::WIN_MIN_RST;
            y_max = cpw_pkg::WIN_MAX_RST;
            pen_x = '0;
            pen_y = '0;
            walk_x = '0;
            walk_y = '0;
            end_x = '0;
            end_y = '0;
            err = '0;
            span_x = '0;
            span_y = '0;
            dir_x_neg = 1'b0;
            dir_y_neg = 1'b0;
            line_active = 1'b0;
            line_color = '0;
            errors = 0;
        endfunction

        function void set_window(logic [1:0] idx, t_coord v);
            case (idx)
                cpw_pkg::REG_X_MIN: x_min = v;
                cpw_pkg::REG_X_MAX: x_max = v;
                cpw_pkg::REG_Y_MIN: y_min = v;
                default:            y_max = v;
            endcase
        endfunction

        function void push_pixel();
            cpw_pkg::t_out_pixel px;
            px.pixel_x = walk_x;
            px.pixel_y = walk_y;
            px.pixel_color = line_color;
            px.visible = (walk_x > x_min) && (walk_x < x_max) &&
                         (walk_y > y_min) && (walk_y < y_max);
            px.last = (walk_x == end_x) && (walk_y == end_y);
            if (px.last) begin
                line_active = 1'b0;
            end
            pending_pixels.push_back(px);
        endfunction

        function void note_item(cpw_pkg::t_in_item it);
            t_coord px, py;
            int dx, dy, e2, acc;
            px = it.point_x;
            py = it.point_y;
            case (it.func)
                cpw_pkg::FUNC_MOVE: begin
                    pen_x = px;
                    pen_y = py;
                end
                cpw_pkg::FUNC_DRAW: begin
                    dx = int'(pen_x) - int'(px);
                    dy = int'(pen_y) - int'(py);
                    walk_x = px;
                    walk_y = py;
                    end_x = pen_x;
                    end_y = pen_y;
                    span_x = cpw_pkg::SPAN_BITS'(dx < 0 ? -dx : dx);
                    span_y = cpw_pkg::SPAN_BITS'(dy < 0 ? -dy : dy);
                    dir_x_neg = !(px < end_x);
                    dir_y_neg = !(py < end_y);
                    err = cpw_pkg::ERR_BITS'(int'(span_x) - int'(span_y));
                    line_color = it.color;
                    line_active = 1'b1;
                    pen_x = px;
                    pen_y = py;
                    push_pixel();
                end
                cpw_pkg::FUNC_STEP: begin
                    if (line_active) begin
                        acc = int'(err);
                        e2 = 2 * acc;
                        if (e2 > -int'(span_y)) begin
                            acc = acc - int'(span_y);
                            walk_x = t_coord'(int'(walk_x) + (dir_x_neg ? -1 : 1));
                        end
                        if (e2 < int'(span_x)) begin
                            acc = acc + int'(span_x);
                            walk_y = t_coord'(int'(walk_y) + (dir_y_neg ? -1 : 1));
                        end
                        err = cpw_pkg::ERR_BITS'(acc);
                        push_pixel();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_pixel(cpw_pkg::t_out_pixel got);
            cpw_pkg::t_out_pixel want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: pixel expected none actual %h", $time, got);
                return;
            end
            want = pending_pixels.pop_front();
            check_field("pixel_x", 16'(want.pixel_x), 16'(got.pixel_x));
            check_field("pixel_y", 16'(want.pixel_y), 16'(got.pixel_y));
            check_field("pixel_color", want.pixel_color, got.pixel_color);
            check_field("visible", 16'(want.visible), 16'(got.visible));
            check_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    cpw_pkg::t_in_item in_item = '0;
    logic out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [cpw_pkg::APB_ADDR-1:0] paddr = '0;
    logic [cpw_pkg::APB_DATA-1:0] pwdata = '0;

    logic o_in_stall;
    logic o_out_valid;
    cpw_pkg::t_out_pixel o_out_pixel;
    logic [cpw_pkg::APB_DATA-1:0] prdata;
    logic pready;

    t_line_tracker tracker = new();
    t_rx_mode rx_mode = RX_SPARSE;
    logic hold_req = 1'b0;
    logic gaps_on = 1'b0;
    int burst_left = 1;
    int items_done = 0;
    int rx_tick = 0;
    int idle_cycles = 0;
    int focus_x = 0;
    int focus_y = 0;
    int focus_spread = 2047;

    clipped_line_pixel_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_pixel (o_out_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            tracker.check_pixel(o_out_pixel);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("clipped_line_pixel_walker: mismatch");
            $finish;
        end
    end

    // receiver: per-phase stall pattern, long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                rx_tick++;
                case (rx_mode)
                    RX_NONE:    out_stall <= 1'b0;
                    RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 45);
                    RX_PATTERN: out_stall <= ((rx_tick % 7) < 3);
                    default:    out_stall <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    function automatic t_coord clamp_coord(int v);
        if (v > int'(COORD_HI)) begin
            v = int'(COORD_HI);
        end else if (v < int'(COORD_LO)) begin
            v = int'(COORD_LO);
        end
        return t_coord'(v);
    endfunction

    function automatic t_coord near_coord(int center, int spread);
        return clamp_coord(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic int span_of(t_coord a, t_coord b);
        int d;
        d = int'(a) - int'(b);
        return d < 0 ? -d : d;
    endfunction

    task automatic send_item(input logic [1:0] fn, input t_coord x, input t_coord y,
                             input logic [cpw_pkg::COLOR_BITS-1:0] col);
        cpw_pkg::t_in_item it;
        int gap;
        it.func = fn;
        it.point_x = x;
        it.point_y = y;
        it.color = col;
        if (fn == cpw_pkg::FUNC_MOVE || fn == cpw_pkg::FUNC_DRAW ||
            (fn == cpw_pkg::FUNC_STEP && tracker.line_active)) begin
            items_done++;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_item(it);
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_step();
        send_item(cpw_pkg::FUNC_STEP, t_coord'($urandom), t_coord'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window_reg(input logic [1:0] idx, input t_coord v);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= cpw_pkg::APB_DATA'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        tracker.set_window(idx, v);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic program_window(input t_coord xl, input t_coord xh,
                                  input t_coord yl, input t_coord yh);
        write_window_reg(cpw_pkg::REG_X_MIN, xl);
        write_window_reg(cpw_pkg::REG_X_MAX, xh);
        write_window_reg(cpw_pkg::REG_Y_MIN, yl);
        write_window_reg(cpw_pkg::REG_Y_MAX, yh);
    endtask

    // move (usually), draw, walk the line, with some noise and abandoned lines
    task automatic run_stroke();
        t_coord ax, ay, bx, by;
        int len, steps;
        if ($urandom_range(0, 9) == 0) begin
            ax = t_coord'($urandom);
            ay = t_coord'($urandom);
            bx = t_coord'($urandom);
            by = t_coord'($urandom);
        end else begin
            ax = near_coord(focus_x, focus_spread);
            ay = near_coord(focus_y, focus_spread);
            bx = near_coord(int'(ax), 12);
            by = near_coord(int'(ay), 12);
        end
        if ($urandom_range(0, 9) < 7) begin
            send_item(cpw_pkg::FUNC_MOVE, ax, ay, 16'($urandom));
        end else begin
            ax = tracker.pen_x;
            ay = tracker.pen_y;
        end
        send_item(cpw_pkg::FUNC_DRAW, bx, by, 16'($urandom));
        len = span_of(ax, bx) > span_of(ay, by) ? span_of(ax, bx) : span_of(ay, by);
        steps = len;
        if (len > 48 || $urandom_range(0, 9) == 0) begin
            steps = $urandom_range(0, len > 48 ? 48 : len);
        end
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(FUNC_UNUSED, t_coord'($urandom), t_coord'($urandom),
                              16'($urandom));
                end else begin
                    send_item(cpw_pkg::FUNC_MOVE, near_coord(focus_x, focus_spread),
                              near_coord(focus_y, focus_spread), 16'($urandom));
                end
            end
            send_step();
        end
        if ($urandom_range(0, 4) == 0) begin
            send_step();
        end
    endtask

    initial begin
        int start;
        int cx, cy, hx, hy;
        logic held, paused;
        held = 1'b0;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset window, extremes, special cases
        send_item(cpw_pkg::FUNC_STEP, '0, '0, '0);
        send_item(FUNC_UNUSED, '1, '1, '1);
        send_item(cpw_pkg::FUNC_MOVE, COORD_LO, COORD_HI, '1);
        send_item(cpw_pkg::FUNC_DRAW, COORD_LO, COORD_HI, '1);
        send_item(cpw_pkg::FUNC_STEP, COORD_HI, COORD_LO, '1);
        send_item(cpw_pkg::FUNC_DRAW, COORD_HI, COORD_LO, '0);
        send_step();
        send_step();
        send_item(cpw_pkg::FUNC_MOVE, 12'sd3, -12'sd2, 16'h00ff);
        send_step();
        send_item(cpw_pkg::FUNC_DRAW, '0, '0, 16'h1234);
        repeat (4) send_step();
        send_item(cpw_pkg::FUNC_MOVE, 12'sd0, 12'sd3, '0);
        send_item(cpw_pkg::FUNC_DRAW, '0, '0, 16'hf800);
        repeat (3) send_step();
        send_item(cpw_pkg::FUNC_DRAW, -12'sd1, -12'sd1, 16'ha5a5);
        send_step();

        for (int p = 0; p < PHASES; p++) begin
            wait_for_drain();
            case (p)
                0: begin
                    program_window(cpw_pkg::WIN_MIN_RST, cpw_pkg::WIN_MAX_RST,
                                   cpw_pkg::WIN_MIN_RST, cpw_pkg::WIN_MAX_RST);
                    focus_x = 0;
                    focus_y = 0;
                    focus_spread = 40;
                    rx_mode = RX_RANDOM;
                    gaps_on = 1'b1;
                end
                1: begin
                    program_window(COORD_LO, COORD_HI, COORD_LO, COORD_HI);
                    focus_spread = 2047;
                    rx_mode = RX_NONE;
                    gaps_on = 1'b0;
                end
                2: begin
                    cx = int'($urandom_range(0, 3800)) - 1900;
                    cy = int'($urandom_range(0, 3800)) - 1900;
                    hx = $urandom_range(0, 30);
                    hy = $urandom_range(0, 30);
                    program_window(t_coord'(cx - hx), t_coord'(cx + hx),
                                   t_coord'(cy - hy), t_coord'(cy + hy));
                    focus_x = cx;
                    focus_y = cy;
                    focus_spread = 40;
                    rx_mode = RX_PATTERN;
                    gaps_on = 1'b0;
                end
                3: begin
                    program_window(COORD_HI, COORD_LO, 12'sd5, 12'sd5);
                    focus_x = 0;
                    focus_y = 5;
                    focus_spread = 100;
                    rx_mode = RX_SPARSE;
                    gaps_on = 1'b1;
                end
                4: begin
                    program_window(t_coord'($urandom), t_coord'($urandom),
                                   t_coord'($urandom), t_coord'($urandom));
                    focus_x = 0;
                    focus_y = 0;
                    focus_spread = 2047;
                    rx_mode = RX_RANDOM;
                    gaps_on = 1'b1;
                end
                default: begin
                    program_window(COORD_LO, t_coord'(int'(COORD_LO) + 8),
                                   t_coord'(int'(COORD_HI) - 7), COORD_HI);
                    focus_x = int'(COORD_LO) + 4;
                    focus_y = int'(COORD_HI) - 4;
                    focus_spread = 10;
                    rx_mode = RX_PATTERN;
                    gaps_on = 1'b1;
                end
            endcase
            start = items_done;
            while (items_done - start < PHASE_ITEMS) begin
                if (p == 2 && !held && items_done - start > 60) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                if (p == 4 && !paused && items_done - start > 100) begin
                    wait_for_drain();
                    paused = 1'b1;
                end
                run_stroke();
            end
        end

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_pixels.size() == 0) begin
            $display("clipped_line_pixel_walker: match");
        end else begin
            $display("clipped_line_pixel_walker: mismatch");
        end
        $finish;
    end

endmodule
